// File: hw/rtl/text_console_cursor_control_defines.svh
`ifndef TEXT_CONSOLE_CURSOR_CONTROL_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_CONTROL_DEFINES_SVH

// Check that cond holds in the same cycle whenever trig holds.
`define TCCC_ASSERT_NOW(label, clk, rst, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("tccc check failed");

// Check that cond holds in the cycle after trig.
`define TCCC_ASSERT_NEXT(label, clk, rst, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("tccc check failed");

`endif

// File: hw/rtl/tccc_pkg.sv
`default_nettype none

package tccc_pkg;

  // Display command codes
  localparam logic [1:0] OP_DRAW   = 2'd0;
  localparam logic [1:0] OP_CLEAR  = 2'd1;
  localparam logic [1:0] OP_SCROLL = 2'd2;

  // Control bytes
  localparam logic [7:0] CHAR_EOL = 8'h03;
  localparam logic [7:0] CHAR_FF  = 8'h0C;
  localparam logic [7:0] CHAR_NL  = 8'h0A;
  localparam logic [7:0] CHAR_CR  = 8'h0D;

  localparam logic [6:0] SPACE_GLYPH = 7'd32;

  typedef enum logic [2:0] {
    CC_PRINT,
    CC_EOL,
    CC_FF,
    CC_NL,
    CC_CR,
    CC_SETCOL,
    CC_SETROW,
    CC_IGNORE
  } char_class_t;

  typedef enum logic [2:0] {
    CUR_HOLD,
    CUR_HOME,
    CUR_COL0,
    CUR_NEXT_ROW,
    CUR_SET_COL,
    CUR_SET_ROW,
    CUR_ADV
  } cur_op_t;

  typedef enum logic [1:0] {
    EMIT_SCROLL,
    EMIT_SPACE,
    EMIT_GLYPH,
    EMIT_CLEAR
  } emit_kind_t;

  typedef struct packed {
    logic       load_char;
    cur_op_t    cur_op;
    logic       sweep_load;
    logic       sweep_step;
    logic       emit;
    emit_kind_t emit_kind;
    logic       emit_last;
  } tccc_cmd_t;

  typedef struct packed {
    logic        can_load;
    logic        col_pending;
    logic        row_bottom;
    logic        sweep_done;
    char_class_t char_class;
  } tccc_status_t;

  function automatic char_class_t classify(input logic [7:0] code);
    char_class_t cls;
    cls = CC_PRINT;
    if (code == CHAR_EOL) begin
      cls = CC_EOL;
    end else if (code == CHAR_FF) begin
      cls = CC_FF;
    end else if (code == CHAR_NL) begin
      cls = CC_NL;
    end else if (code == CHAR_CR) begin
      cls = CC_CR;
    end else if (code inside {[8'h80:8'h8F]}) begin
      cls = CC_SETCOL;
    end else if (code inside {[8'h90:8'h9F]}) begin
      cls = CC_SETROW;
    end else if (code inside {[8'hA0:8'hFF]}) begin
      cls = CC_IGNORE;
    end
    return cls;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/tccc_ctrl.sv
`default_nettype none

module tccc_ctrl
  import tccc_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire tccc_status_t status,
  output tccc_cmd_t         cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCROLL,
    ST_SWEEP,
    ST_GLYPH,
    ST_CLEAR
  } state_t;

  state_t state, state_next;
  logic   glyph_after, glyph_after_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      glyph_after <= 1'b0;
    end else begin
      state       <= state_next;
      glyph_after <= glyph_after_next;
    end
  end

  always_comb begin
    state_next       = state;
    glyph_after_next = glyph_after;
    cmd              = '0;
    cmd.cur_op       = CUR_HOLD;
    cmd.emit_kind    = EMIT_GLYPH;
    s_tready         = (state == ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load_char = 1'b1;
          case (status.char_class)
            CC_EOL: begin
              if (!status.col_pending) begin
                cmd.sweep_load   = 1'b1;
                glyph_after_next = 1'b0;
                state_next       = ST_SWEEP;
              end
            end
            CC_FF: begin
              cmd.cur_op = CUR_HOME;
              state_next = ST_CLEAR;
            end
            CC_NL: begin
              if (!status.row_bottom) begin
                cmd.cur_op = CUR_NEXT_ROW;
              end else begin
                cmd.cur_op       = CUR_COL0;
                glyph_after_next = 1'b0;
                state_next       = ST_SCROLL;
              end
            end
            CC_CR:     cmd.cur_op = CUR_COL0;
            CC_SETCOL: cmd.cur_op = CUR_SET_COL;
            CC_SETROW: cmd.cur_op = CUR_SET_ROW;
            CC_IGNORE: cmd.cur_op = CUR_HOLD;
            CC_PRINT: begin
              if (!status.col_pending) begin
                state_next = ST_GLYPH;
              end else if (!status.row_bottom) begin
                cmd.cur_op = CUR_NEXT_ROW;
                state_next = ST_GLYPH;
              end else begin
                cmd.cur_op       = CUR_COL0;
                glyph_after_next = 1'b1;
                state_next       = ST_SCROLL;
              end
            end
            default: cmd.cur_op = CUR_HOLD;
          endcase
        end
      end
      ST_SCROLL: begin
        if (status.can_load) begin
          cmd.emit       = 1'b1;
          cmd.emit_kind  = EMIT_SCROLL;
          cmd.sweep_load = 1'b1;
          state_next     = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if (status.can_load) begin
          cmd.emit       = 1'b1;
          cmd.emit_kind  = EMIT_SPACE;
          cmd.emit_last  = status.sweep_done && !glyph_after;
          cmd.sweep_step = 1'b1;
          if (status.sweep_done) begin
            state_next = glyph_after ? ST_GLYPH : ST_IDLE;
          end
        end
      end
      ST_GLYPH: begin
        if (status.can_load) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = EMIT_GLYPH;
          cmd.emit_last = 1'b1;
          cmd.cur_op    = CUR_ADV;
          state_next    = ST_IDLE;
        end
      end
      ST_CLEAR: begin
        if (status.can_load) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = EMIT_CLEAR;
          cmd.emit_last = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/tccc_dp.sv
`default_nettype none

module tccc_dp
  import tccc_pkg::*;
#(
  parameter int COLS = 16,
  parameter int ROWS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_wdata,
  input  wire logic [7:0]  s_tdata,
  input  wire tccc_cmd_t   cmd,
  output tccc_status_t     status,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,
  output logic [1:0]       m_tuser,
  output logic             m_tlast
);

  localparam int CW = $clog2(COLS + 1);
  localparam int RW = $clog2(ROWS);

  logic          fg_color;
  logic [CW-1:0] cursor_col;
  logic [RW-1:0] cursor_row;
  logic [CW-1:0] sweep_col;
  logic [6:0]    char_reg;

  logic [7:0]    set_val;
  logic [CW-1:0] col_sat;
  logic [RW-1:0] row_sat;
  logic [7:0]    sweep_col_w;
  logic [7:0]    cursor_col_w;
  logic [7:0]    cursor_row_w;

  assign set_val      = {4'b0, s_tdata[3:0]};
  assign col_sat      = (set_val > 8'(COLS)) ? CW'(COLS) : CW'(set_val);
  assign row_sat      = (set_val > 8'(ROWS - 1)) ? RW'(ROWS - 1) : RW'(set_val);
  assign sweep_col_w  = 8'(sweep_col);
  assign cursor_col_w = 8'(cursor_col);
  assign cursor_row_w = 8'(cursor_row);

  assign status.can_load    = !m_tvalid || m_tready;
  assign status.col_pending = (cursor_col == CW'(COLS));
  assign status.row_bottom  = (cursor_row == RW'(ROWS - 1));
  assign status.sweep_done  = (sweep_col == CW'(COLS - 1));
  assign status.char_class  = classify(s_tdata);

  always_ff @(posedge clk) begin
    if (rst) begin
      fg_color <= 1'b1;
    end else if (cfg_we) begin
      fg_color <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_col <= '0;
      cursor_row <= '0;
    end else begin
      case (cmd.cur_op)
        CUR_HOME: begin
          cursor_col <= '0;
          cursor_row <= '0;
        end
        CUR_COL0: cursor_col <= '0;
        CUR_NEXT_ROW: begin
          cursor_col <= '0;
          cursor_row <= cursor_row + RW'(1);
        end
        CUR_SET_COL: cursor_col <= col_sat;
        CUR_SET_ROW: cursor_row <= row_sat;
        CUR_ADV:     cursor_col <= cursor_col + CW'(1);
        default: begin
          cursor_col <= cursor_col;
          cursor_row <= cursor_row;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_char) begin
      char_reg <= s_tdata[6:0];
    end
    if (cmd.sweep_load) begin
      sweep_col <= cursor_col;
    end else if (cmd.sweep_step) begin
      sweep_col <= sweep_col + CW'(1);
    end
  end

  // Output register: load a command, drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tlast <= cmd.emit_last;
      case (cmd.emit_kind)
        EMIT_SCROLL: begin
          m_tuser <= OP_SCROLL;
          m_tdata <= {1'b0, ~fg_color, 14'd0};
        end
        EMIT_CLEAR: begin
          m_tuser <= OP_CLEAR;
          m_tdata <= {1'b0, ~fg_color, 14'd0};
        end
        EMIT_SPACE: begin
          m_tuser <= OP_DRAW;
          m_tdata <= {1'b0, fg_color, SPACE_GLYPH, cursor_row_w[2:0], sweep_col_w[3:0]};
        end
        default: begin
          m_tuser <= OP_DRAW;
          m_tdata <= {1'b0, fg_color, char_reg, cursor_row_w[2:0], cursor_col_w[3:0]};
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/text_console_cursor_control.sv
// Channel  | Dir | Signals                        | Content
// ---------+-----+--------------------------------+----------------------------------------
// input    | in  | s_tvalid s_tready s_tdata[7:0] | char_code
// output   | out | m_tvalid m_tready m_tdata[15:0]| cell_col, cell_row, glyph, ink, pad bit
//          |     | m_tuser[1:0] m_tlast           | op_kind; last command of the item
// config   | in  | cfg_we cfg_wdata               | fg_color
//
// Cursor sets, carriage return, ignored bytes and a newline above the bottom row
// emit nothing; a line clear blanks the row from the cursor to the right edge,
// a newline on the bottom row scrolls and blanks it, a wrapped glyph there
// scrolls, blanks and draws. The single output register moves one command per
// cycle while m_tready is high; the sequencer takes a new item only when idle.
// Reset (rst, synchronous) homes the cursor, sets fg_color to 1 and empties the
// output. A low m_tready holds the sequencer in place until the command is taken.
`default_nettype none

`include "text_console_cursor_control_defines.svh"

module text_console_cursor_control
  import tccc_pkg::*;
#(
  parameter int COLS = 16,
  parameter int ROWS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration: fg_color
  input  wire logic        cfg_we,
  input  wire logic        cfg_wdata,
  // input items
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] char_code
  // output items
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // [3:0] cell_col, [6:4] cell_row, [13:7] glyph,
                                      // [14] ink, [15] zero
  output logic [1:0]       m_tuser,   // [1:0] op_kind
  output logic             m_tlast    // last command of this item
);

  tccc_cmd_t    cmd;
  tccc_status_t status;

  // Sequencer: decode the byte and walk scroll, line sweep, glyph and clear steps
  tccc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // Cursor, sweep counter, color register and output register
  tccc_dp #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tdata   (s_tdata),
    .cmd       (cmd),
    .status    (status),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  // Never overwrite a command that still waits downstream
  `TCCC_ASSERT_NOW(a_no_overwrite, clk, rst, cmd.emit, status.can_load)
  // A scroll is always followed by the blanking of the bottom row
  `TCCC_ASSERT_NOW(a_scroll_not_last, clk, rst, m_tvalid && (m_tuser == OP_SCROLL), !m_tlast)
  // A screen clear ends its item
  `TCCC_ASSERT_NOW(a_clear_last, clk, rst, m_tvalid && (m_tuser == OP_CLEAR), m_tlast)
  // Once a scroll is loaded the sequencer does not accept input (s_tready low)
  `TCCC_ASSERT_NEXT(a_scroll_then_space, clk, rst,
                    cmd.emit && (cmd.emit_kind == EMIT_SCROLL), s_tready == 1'b0)

endmodule

`default_nettype wire

// File: tb/text_console_cursor_control_tb.sv
`timescale 1ns / 1ps

module text_console_cursor_control_tb;
  import tccc_pkg::*;

  localparam int COLS          = 16;
  localparam int ROWS          = 8;
  localparam int CLK_HALF      = 10;
  // Settle time after the last expected command is seen, sized from the longest item
  // (a wrapped glyph on the bottom row).
  localparam int SETTLE_CYCLES = 2 * (COLS + 3);
  localparam int DRAIN_LIMIT   = 20000;
  localparam int HOLD_CYCLES   = 300;

  // One display command as the block should emit it.
  typedef struct packed {
    logic [1:0] op_kind;
    logic [3:0] cell_col;
    logic [2:0] cell_row;
    logic [6:0] glyph;
    logic       ink;
    logic       is_last;
  } console_cmd_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        cfg_we    = 1'b0;
  logic        cfg_wdata = 1'b0;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata   = 8'h00;  // [7:0] char_code
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [15:0] m_tdata;            // [3:0] cell_col, [6:4] cell_row, [13:7] glyph, [14] ink
  logic [1:0]  m_tuser;            // [1:0] op_kind
  logic        m_tlast;

  // Predicted cursor and color register, mirrored from accepted items.
  logic [4:0]  cursor_col;
  logic [2:0]  cursor_row;
  logic        fg_ink;

  console_cmd_t pending_cmds[$];   // commands still owed by the block, oldest first
  console_cmd_t cmd_batch[$];      // commands caused by the item being predicted

  int send_idle_pct  = 0;
  int recv_idle_pct  = 0;
  int hold_request   = 0;
  bit failed         = 1'b0;

  text_console_cursor_control #(
    .COLS(COLS),
    .ROWS(ROWS)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #CLK_HALF clk = ~clk;

  // Hard stop in case the block hangs or loses its handshake.
  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Command predictor
  // ---------------------------------------------------------------------------

  function automatic void push_cmd(input logic [1:0] op, input logic [3:0] col,
                                   input logic [2:0] row, input logic [6:0] glyph,
                                   input logic ink);
    console_cmd_t cmd;
    cmd.op_kind  = op;
    cmd.cell_col = col;
    cmd.cell_row = row;
    cmd.glyph    = glyph;
    cmd.ink      = ink;
    cmd.is_last  = 1'b0;
    cmd_batch.push_back(cmd);
  endfunction

  // Blank the cursor row from the cursor to the right edge; cursor stays put.
  function automatic void blank_to_eol();
    for (int c = int'(cursor_col); c < COLS; c++) begin
      push_cmd(OP_DRAW, c[3:0], cursor_row, SPACE_GLYPH, fg_ink);
    end
  endfunction

  // Step down one row, or scroll and blank the bottom row when already there.
  function automatic void line_feed();
    if (int'(cursor_row) + 1 < ROWS) begin
      cursor_row = cursor_row + 3'd1;
      cursor_col = 5'd0;
    end else begin
      push_cmd(OP_SCROLL, 4'd0, 3'd0, 7'd0, ~fg_ink);
      cursor_col = 5'd0;
      blank_to_eol();
    end
  endfunction

  // Work out every command one accepted character causes and queue them.
  function automatic void predict_console(input logic [7:0] code);
    cmd_batch.delete();
    if (code == CHAR_EOL) begin
      blank_to_eol();
    end else if (code == CHAR_FF) begin
      cursor_col = 5'd0;
      cursor_row = 3'd0;
      push_cmd(OP_CLEAR, 4'd0, 3'd0, 7'd0, ~fg_ink);
    end else if (code == CHAR_NL) begin
      line_feed();
    end else if (code == CHAR_CR) begin
      cursor_col = 5'd0;
    end else if (code[7]) begin
      // 0x80..0x8F set the column, 0x90..0x9F the row, the rest is dropped
      if (code[6:5] == 2'b00 && !code[4]) begin
        cursor_col = (int'(code[3:0]) > COLS) ? 5'(COLS) : {1'b0, code[3:0]};
      end else if (code[6:5] == 2'b00) begin
        cursor_row = (int'(code[3:0]) > ROWS - 1) ? 3'(ROWS - 1) : code[2:0];
      end
    end else begin
      // Printable and stray control bytes: resolve a pending wrap first.
      if (int'(cursor_col) >= COLS) begin
        line_feed();
      end
      push_cmd(OP_DRAW, cursor_col[3:0], cursor_row, code[6:0], fg_ink);
      cursor_col = cursor_col + 5'd1;
    end
    if (cmd_batch.size() > 0) begin
      cmd_batch[cmd_batch.size() - 1].is_last = 1'b1;
    end
    foreach (cmd_batch[i]) begin
      pending_cmds.push_back(cmd_batch[i]);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Output side: ready generation and command checking
  // ---------------------------------------------------------------------------

  // Drive m_tready at the falling edge; a hold request forces a long stall.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        m_tready = 1'b0;
        hold_left--;
      end else begin
        m_tready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic check_field(input string name, input int expected, input int actual);
    if (expected != actual) begin
      $error("%s mismatch: expected %0d, got %0d", name, expected, actual);
      failed = 1'b1;
    end
  endtask

  // Compare each taken command with the oldest one still owed.
  always @(posedge clk) begin
    console_cmd_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_cmds.size() == 0) begin
        $error("unexpected command: op_kind %0d tdata 0x%04h last %0b",
               m_tuser, m_tdata, m_tlast);
        failed = 1'b1;
      end else begin
        want = pending_cmds.pop_front();
        check_field("op_kind",  want.op_kind,  m_tuser);
        check_field("cell_col", want.cell_col, m_tdata[3:0]);
        check_field("cell_row", want.cell_row, m_tdata[6:4]);
        check_field("glyph",    want.glyph,    m_tdata[13:7]);
        check_field("ink",      want.ink,      m_tdata[14]);
        check_field("last",     want.is_last,  m_tlast);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Offer one character; entered and left at a falling edge with tvalid held.
  task automatic send_char(input logic [7:0] code);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = code;
    @(posedge clk);
    while (!s_tready) begin
      @(posedge clk);
    end
    predict_console(code);
    @(negedge clk);
  endtask

  // Stop offering, wait for every owed command, then let the block go quiet.
  task automatic wait_for_drain();
    int waited;
    waited   = 0;
    s_tvalid = 1'b0;
    while (pending_cmds.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    if (pending_cmds.size() != 0) begin
      $error("%0d expected commands never arrived", pending_cmds.size());
      failed = 1'b1;
      pending_cmds.delete();
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write the ink register; call only with the block idle.
  task automatic write_fg(input logic value);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we    = 1'b0;
    fg_ink    = value;
  endtask

  // Mostly printable text, with line controls and cursor moves mixed in.
  function automatic logic [7:0] pick_char();
    int roll;
    roll = $urandom_range(99);
    if (roll < 55) return 8'($urandom_range(8'h20, 8'h7E));
    if (roll < 63) return 8'($urandom_range(8'h00, 8'h7F));
    if (roll < 71) return CHAR_NL;
    if (roll < 76) return CHAR_EOL;
    if (roll < 78) return CHAR_FF;
    if (roll < 83) return CHAR_CR;
    if (roll < 89) return 8'($urandom_range(8'h80, 8'h8F));
    if (roll < 95) return 8'($urandom_range(8'h90, 8'h9F));
    return 8'($urandom_range(8'hA0, 8'hFF));
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Glyph extremes, a stray control byte drawn as a glyph, and a space.
  task automatic test_glyphs();
    send_char(8'h41);
    send_char(8'h00);
    send_char(8'h7F);
    send_char(8'h09);
    send_char(8'h20);
  endtask

  // Line clears, carriage return, newline above and on the bottom row, form feed.
  task automatic test_line_controls();
    send_char(CHAR_EOL);   // partial row
    send_char(CHAR_CR);
    send_char(CHAR_EOL);   // whole row
    send_char(CHAR_NL);    // plain move down
    send_char(8'h97);
    send_char(CHAR_NL);    // scroll and blank the bottom row
    send_char(CHAR_FF);
  endtask

  // Column and row sets, saturation, pending wrap and ignored bytes.
  task automatic test_cursor_sets();
    send_char(8'h8F);
    send_char(8'h5A);      // fills the last column, wrap now pending
    send_char(CHAR_EOL);   // nothing to clear with a wrap pending
    send_char(8'h9F);      // row saturates to the bottom
    send_char(8'h7A);      // wrap on the bottom row: scroll, blank, draw
    send_char(8'h80);
    send_char(8'h98);
    send_char(8'h90);
    send_char(8'hA0);
    send_char(8'hFF);
    send_char(8'h8F);
    send_char(8'h71);
    send_char(8'h72);      // wrap above the bottom row
  endtask

  // Hold the output off for a long stretch while items keep coming in.
  task automatic test_receiver_hold();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request  = HOLD_CYCLES;
    send_char(8'h97);
    send_char(8'h8F);
    send_char(8'h78);
    send_char(8'h79);
    send_char(CHAR_NL);
    send_char(8'h6B);
    send_char(CHAR_EOL);
    send_char(8'h6C);
  endtask

  task automatic test_random(input int count, input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int i = 0; i < count; i++) begin
      send_char(pick_char());
      // Now and then pause the input until the output has caught up.
      if ($urandom_range(39) == 0) begin
        wait_for_drain();
      end
    end
  endtask

  initial begin
    cursor_col = 5'd0;
    cursor_row = 3'd0;
    fg_ink     = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_glyphs();
    test_line_controls();
    test_cursor_sets();
    wait_for_drain();

    write_fg(1'b0);
    test_receiver_hold();
    wait_for_drain();

    write_fg(1'b1);
    test_random(76, 25, 64);
    wait_for_drain();

    write_fg(1'b0);
    test_random(76, 64, 25);
    wait_for_drain();

    write_fg(1'b1);
    test_random(76, 0, 0);
    wait_for_drain();

    if (!failed) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
